>>> rtl/itoa_pkg.sv
// Shared constants, types and elaboration helpers for the integer-to-ASCII converter.
`default_nettype none

package itoa_pkg;

    // Default operand width
    localparam int VALUE_BITS_DEF = 32;

    // Character codes
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    // Control word to the character emitter: start from the BCD converter's done, neg from the top level
    typedef struct packed {
        logic start;
        logic neg;
    } itoa_ctl_t;

    // Number of decimal digits of 2^(bits-1), the largest magnitude seen
    function automatic int dec_digits(input int bits);
        logic [64:0] p;
        int          n;
        p = 65'd1 << (bits - 1);
        n = 0;
        for (int i = 0; i < 21; i++) begin
            if (p != 65'd0) begin
                p = p / 65'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/itoa_dabble.sv
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
`default_nettype none

module itoa_dabble #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
    parameter int NDIG       = itoa_pkg::dec_digits(itoa_pkg::VALUE_BITS_DEF)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] mag,
    output logic                       done,
    output logic [NDIG*4-1:0]          bcd
);
    import itoa_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [NDIG*4-1:0]     bcd_reg, bcd_next;
    logic [NDIG*4-1:0]     adj;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    // Add 3 to every digit of five or more (digits are independent)
    always_comb
    begin
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
                adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            else
                adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
        end
    end

    // One shift step per cycle while running
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            bcd_next = {adj[NDIG*4-2:0], bin_reg[VALUE_BITS-1]};
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VALUE_BITS - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

>>> rtl/itoa_emit.sv
// Character emitter: strips leading zeros, sends sign and digits through an output register.
`default_nettype none

module itoa_emit #(
    parameter int NDIG = itoa_pkg::dec_digits(itoa_pkg::VALUE_BITS_DEF)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire itoa_pkg::itoa_ctl_t ctl,
    input  wire logic [NDIG*4-1:0]  bcd_in,
    output logic                    finish,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              char_code,
    output logic                    last
);
    import itoa_pkg::*;

    localparam int CW = $clog2(NDIG + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [NDIG*4-1:0] bcd_reg, bcd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              valid_reg, valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic              slot_free;
    logic [3:0]        top_digit;

    assign slot_free = !valid_reg || out_ready;
    assign top_digit = bcd_reg[NDIG*4-1 -: 4];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start) begin
                    bcd_next   = bcd_in;
                    neg_next   = ctl.neg;
                    cnt_next   = CW'(NDIG);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop one leading zero a cycle, keep at least one digit
                if (top_digit == 4'd0 && cnt_reg > CW'(1)) begin
                    bcd_next = {bcd_reg[NDIG*4-5:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                end else if (neg_reg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free) begin
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    valid_next = 1'b1;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free) begin
                    char_next  = CHAR_ZERO + {4'd0, top_digit};
                    last_next  = (cnt_reg == CW'(1));
                    valid_next = 1'b1;
                    bcd_next   = {bcd_reg[NDIG*4-5:0], 4'd0};
                    cnt_next   = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                        finish     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii_top.sv
// Top level: signed integer to decimal ASCII text, one character per output word.
// Flow: after accept, the magnitude passes through the one-bit-a-cycle shift-add-3 unit;
// the emitter then strips up to NDIG-1 leading zeros, sends a minus sign for a negative
// value and then the digits, one character per cycle while out_ready is high.
// A new value is accepted only once the final character of the previous one is loaded.
// Reset: rst_n asynchronous, active low; clears the busy flag and output valid.
`default_nettype none

module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 char_code,
    output logic                       last
);
    import itoa_pkg::*;

    localparam int NDIG = dec_digits(VALUE_BITS);

    logic                  busy_reg, busy_next;
    logic                  neg_reg;
    logic                  accept;
    logic [VALUE_BITS-1:0] mag;
    logic                  conv_done;
    logic [NDIG*4-1:0]     bcd;
    logic                  finish;
    itoa_ctl_t             ctl;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && !busy_reg;

    // Magnitude; the most negative value wraps to 2^(VALUE_BITS-1) unsigned
    assign mag = value[VALUE_BITS-1] ? VALUE_BITS'(~value + 1'b1) : value;

    // Busy from accept until the final character is loaded
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (finish)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            neg_reg <= value[VALUE_BITS-1];
    end

    assign ctl.start = conv_done;
    assign ctl.neg   = neg_reg;

    itoa_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .mag   (mag),
        .done  (conv_done),
        .bcd   (bcd)
    );

    itoa_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .bcd_in    (bcd),
        .finish    (finish),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last)
    );

endmodule

`default_nettype wire
